// ===== rtl/core/multi_slot_countdown_timer_macros.svh =====
// Assertion macros for the multi-slot countdown timer.
`ifndef MULTI_SLOT_COUNTDOWN_TIMER_MACROS_SVH
`define MULTI_SLOT_COUNTDOWN_TIMER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define MSCT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define MSCT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSCT_ASSERT(label, clk, rstn, prop, msg)
`define MSCT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/msct_pkg.sv =====
// Shared types, codes and widths of the multi-slot countdown timer.
package msct_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int OWNER_BITS_DEF = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CMD_W   = 3;
    localparam int OWNER_W = 8;
    localparam int DUR_W   = 32;
    localparam int TAG_W   = 8;
    localparam int ID_W    = 5;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - (1 + ID_W + DUR_W + OWNER_W + TAG_W);

    localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP_ID  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP_OWN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMAIN   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd5;
    // internal code for the unused command values
    localparam logic [CMD_W-1:0] CMD_NONE     = 3'd6;

    // input item as it sits in s_tdata, lowest field last
    typedef struct packed {
        logic [ID_W-1:0]    timer_id;
        logic [TAG_W-1:0]   tag;
        logic [DUR_W-1:0]   duration;
        logic [OWNER_W-1:0] owner;
        logic [CMD_W-1:0]   command;
    } msct_in_t;

    // classified command as held in the queue
    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [OWNER_W-1:0] owner;
        logic [DUR_W-1:0]   duration;
        logic [TAG_W-1:0]   tag;
        logic [ID_W-1:0]    timer_id;
        logic               id_ok;
    } msct_cmd_t;

    // one result item
    typedef struct packed {
        logic               ok;
        logic [ID_W-1:0]    id;
        logic [DUR_W-1:0]   remaining;
        logic [OWNER_W-1:0] owner;
        logic [TAG_W-1:0]   tag;
        logic               expired;
    } msct_res_t;

    // result item as it sits in m_tdata, lowest field last
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic [TAG_W-1:0]   tag;
        logic [OWNER_W-1:0] owner;
        logic [DUR_W-1:0]   remaining;
        logic [ID_W-1:0]    id;
        logic               ok;
    } msct_out_t;

endpackage

// ===== rtl/core/multi_slot_countdown_timer.sv =====
// Top level of the multi-slot countdown timer.
//
// Table of SLOTS one-shot countdown timers, ids 1..SLOTS, driven by command items.
// Input channel s_*: one command item per handshake (start, tick, stop id,
// stop owner, remaining-time query, owner-and-tag query).
// Result channel m_*: one result item per command, or one item per expired
// timer for a tick in ascending id order; m_tlast marks the final item of a
// command and m_tuser flags an expiry report.
// Flow: a command sits in a two-entry queue, then the executor scans all
// slots one per cycle through the slot memory while its scan is not paused;
// the slot scan sets how long a command takes.
// A stalled receiver holds the result register; a tick that has a second
// expiry to report then pauses its scan until the register frees up, and
// the queue keeps taking commands until it fills.
// Reset (aresetn low, synchronous) frees every timer and empties the queue
// and the result register; slot contents are written before use.
`include "multi_slot_countdown_timer_macros.svh"

module multi_slot_countdown_timer import msct_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[2:0], owner[10:3], duration[42:11], tag[50:43], timer_id[55:51]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // ok[0], result_id[5:1], remaining[37:6], result_owner[45:38],
    // result_tag[53:46], zero fill[55:54]
    output logic [M_TDATA_W-1:0] m_tdata,
    // expired[0]
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic      push_valid, push_ready;
    msct_cmd_t push_cmd;
    logic      q_valid, q_ready;
    msct_cmd_t q_cmd;
    msct_res_t out_res;
    msct_out_t out_word;

    // unpack and classify each item before it is queued
    msct_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd)
    );

    // decouple acceptance from execution
    msct_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_cmd   (q_cmd)
    );

    // scan the table and drive the registered result
    msct_exec #(
        .SLOTS     (SLOTS),
        .OWNER_BITS(OWNER_BITS)
    ) u_exec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_valid),
        .cmd_ready(q_ready),
        .cmd      (q_cmd),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (out_res),
        .m_last   (m_tlast)
    );

    // pack the result fields, lowest field in the lowest bits
    always_comb begin
        out_word.pad       = '0;
        out_word.tag       = out_res.tag;
        out_word.owner     = out_res.owner;
        out_word.remaining = out_res.remaining;
        out_word.id        = out_res.id;
        out_word.ok        = out_res.ok;
    end

    assign m_tdata = M_TDATA_W'(out_word);
    assign m_tuser = out_res.expired;

    // an expiry report always succeeds and carries no remaining time
    `MSCT_ASSERT(a_expiry_fields, aclk, aresetn, (m_tvalid && m_tuser) |-> (out_res.ok && out_res.remaining == '0), "expiry report with bad fields")
    // only tick expiries produce more than one result per command
    `MSCT_ASSERT(a_multi_only_tick, aclk, aresetn, (m_tvalid && !m_tlast) |-> m_tuser, "non-final result that is not an expiry")
    // a command taken from the queue keeps the executor busy for the next cycle
    `MSCT_ASSERT_NEXT(a_pop_busy, aclk, aresetn, (q_valid && q_ready), !q_ready, "executor took two commands back to back")

endmodule

// ===== rtl/core/msct_front.sv =====
// Front end: unpack and classify input items for the command queue.
module msct_front import msct_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 push_valid,
    input  logic                 push_ready,
    output msct_cmd_t            push_cmd
);

    msct_in_t in_item;

    assign in_item    = msct_in_t'(s_tdata);
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

    always_comb begin
        push_cmd.owner    = in_item.owner;
        push_cmd.duration = in_item.duration;
        push_cmd.tag      = in_item.tag;
        push_cmd.timer_id = in_item.timer_id;
        // id names a slot only when it is nonzero and within the table
        push_cmd.id_ok    = (in_item.timer_id != '0) &&
                            (32'(in_item.timer_id) <= 32'(SLOTS));
        case (in_item.command)
            CMD_START, CMD_TICK, CMD_STOP_ID, CMD_STOP_OWN, CMD_REMAIN,
            CMD_CONTAINS: begin
                push_cmd.op = in_item.command;
            end
            default: begin
                push_cmd.op = CMD_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/core/msct_queue.sv =====
// Short command queue between the front end and the executor.
module msct_queue import msct_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  msct_cmd_t push_cmd,
    output logic      pop_valid,
    input  logic      pop_ready,
    output msct_cmd_t pop_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    msct_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/msct_exec.sv =====
// Executor: scans the timer table one slot a cycle while its scan is not paused, and issues results.
module msct_exec import msct_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  msct_cmd_t cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output msct_res_t m_res,
    output logic      m_last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int OW = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    msct_cmd_t        cur_reg, cur_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [SW-1:0]    ev_idx_reg, ev_idx_next;
    logic [SLOTS-1:0] act_reg, act_next;
    logic             found_reg, found_next;
    msct_res_t        hold_reg, hold_next;
    logic             m_valid_reg, m_valid_next;
    msct_res_t        m_res_reg, m_res_next;
    logic             m_last_reg, m_last_next;

    logic [DUR_W-1:0] rem_mem [SLOTS];
    logic [OW-1:0]    own_mem [SLOTS];
    logic [TAG_W-1:0] tag_mem [SLOTS];
    logic [DUR_W-1:0] rd_rem_reg;
    logic [OW-1:0]    rd_own_reg;
    logic [TAG_W-1:0] rd_tag_reg;

    logic             out_free, adv, rd_en, wr_all, wr_rem;
    logic             ev_act, own_eq, tag_eq, expire, id_hit, need_push;
    logic [OW-1:0]    own_in;
    logic [DUR_W-1:0] wr_rem_val;
    logic [31:0]      ev_id;
    logic             issue;

    assign out_free  = !m_valid_reg || m_ready;
    assign ev_act    = act_reg[ev_idx_reg];
    assign own_in    = cur_reg.owner[OW-1:0];
    assign own_eq    = (rd_own_reg == own_in);
    assign tag_eq    = (rd_tag_reg == cur_reg.tag);
    assign expire    = (rd_rem_reg <= cur_reg.duration);
    assign ev_id     = 32'(ev_idx_reg) + 32'd1;
    assign id_hit    = cur_reg.id_ok && (ev_id == 32'(cur_reg.timer_id));
    // a second expiry pushes the one held back before it
    assign need_push = ev_valid_reg && (cur_reg.op == CMD_TICK) && ev_act && expire &&
                       hold_reg.expired;
    assign adv       = !need_push || out_free;
    assign issue     = cnt_reg < CW'(SLOTS);
    assign rd_en     = (state_reg == ST_SCAN) && adv && issue;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_res     = m_res_reg;
    assign m_last    = m_last_reg;

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        ev_valid_next = ev_valid_reg;
        ev_idx_next   = ev_idx_reg;
        act_next      = act_reg;
        found_next    = found_reg;
        hold_next     = hold_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_res_next    = m_res_reg;
        m_last_next   = m_last_reg;
        wr_all        = 1'b0;
        wr_rem        = 1'b0;
        wr_rem_val    = cur_reg.duration;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cur_next      = cmd;
                    cnt_next      = '0;
                    ev_valid_next = 1'b0;
                    found_next    = 1'b0;
                    hold_next     = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (adv) begin
                    if (issue) begin
                        ev_valid_next = 1'b1;
                        ev_idx_next   = cnt_reg[SW-1:0];
                        cnt_next      = cnt_reg + 1'b1;
                    end else begin
                        ev_valid_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                    if (ev_valid_reg) begin
                        case (cur_reg.op)
                            CMD_START: begin
                                if (!ev_act && !found_reg) begin
                                    act_next[ev_idx_reg] = 1'b1;
                                    wr_all               = 1'b1;
                                    wr_rem               = 1'b1;
                                    found_next           = 1'b1;
                                    hold_next.ok         = 1'b1;
                                    hold_next.id         = ID_W'(ev_id);
                                end
                            end
                            CMD_TICK: begin
                                if (ev_act && expire) begin
                                    act_next[ev_idx_reg] = 1'b0;
                                    if (hold_reg.expired) begin
                                        m_valid_next = 1'b1;
                                        m_res_next   = hold_reg;
                                        m_last_next  = 1'b0;
                                    end
                                    hold_next.ok        = 1'b1;
                                    hold_next.id        = ID_W'(ev_id);
                                    hold_next.remaining = '0;
                                    hold_next.owner     = OWNER_W'(rd_own_reg);
                                    hold_next.tag       = rd_tag_reg;
                                    hold_next.expired   = 1'b1;
                                end else if (ev_act) begin
                                    wr_rem     = 1'b1;
                                    wr_rem_val = rd_rem_reg - cur_reg.duration;
                                end
                            end
                            CMD_STOP_ID: begin
                                if (ev_act && id_hit) begin
                                    act_next[ev_idx_reg] = 1'b0;
                                    hold_next.ok         = 1'b1;
                                end
                            end
                            CMD_STOP_OWN: begin
                                if (ev_act && own_eq) begin
                                    act_next[ev_idx_reg] = 1'b0;
                                    hold_next.ok         = 1'b1;
                                end
                            end
                            CMD_REMAIN: begin
                                if (ev_act && id_hit) begin
                                    hold_next.ok        = 1'b1;
                                    hold_next.remaining = rd_rem_reg;
                                end
                            end
                            CMD_CONTAINS: begin
                                if (ev_act && own_eq && tag_eq) begin
                                    hold_next.ok = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ST_DONE: begin
                // final result of the item, or the empty result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = hold_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ev_valid_reg <= 1'b0;
            act_reg      <= '0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ev_valid_reg <= ev_valid_next;
            act_reg      <= act_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        ev_idx_reg <= ev_idx_next;
        hold_reg   <= hold_next;
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
    end

    // slot storage: one write at the slot under evaluation, one read ahead of it
    always_ff @(posedge aclk) begin
        if (wr_rem) begin
            rem_mem[ev_idx_reg] <= wr_rem_val;
        end
        if (wr_all) begin
            own_mem[ev_idx_reg] <= own_in;
            tag_mem[ev_idx_reg] <= cur_reg.tag;
        end
        if (rd_en) begin
            rd_rem_reg <= rem_mem[cnt_reg[SW-1:0]];
            rd_own_reg <= own_mem[cnt_reg[SW-1:0]];
            rd_tag_reg <= tag_mem[cnt_reg[SW-1:0]];
        end
    end

endmodule
